/* rtl/core/timer_deadline_queue_macros.svh */
// assertion helpers for the timer queue
`ifndef TIMER_DEADLINE_QUEUE_MACROS_SVH
`define TIMER_DEADLINE_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
`define TDQ_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define TDQ_ASSERT_NEXT(label, clk, rstn, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) cond |=> expr) \
        else $error("assertion failed");
`else
`define TDQ_ASSERT(label, clk, rstn, prop)
`define TDQ_ASSERT_NEXT(label, clk, rstn, cond, expr)
`endif
`endif

/* rtl/core/tdq_pkg.sv */
package tdq_pkg;

    localparam int Depth = 32;
    localparam int CountW = $clog2(Depth + 1);
    localparam int QDepth = 2;

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_ADD = 2'd1;
    localparam logic [1:0] CMD_CANCEL_HANDLE = 2'd2;
    localparam logic [1:0] CMD_CANCEL_KEY = 2'd3;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_FIRED = 3'd1;
    localparam logic [2:0] ST_ADDED = 3'd2;
    localparam logic [2:0] ST_FULL = 3'd3;
    localparam logic [2:0] ST_CANCELLED = 3'd4;
    localparam logic [2:0] ST_NOT_FOUND = 3'd5;

    // classified command handed from front to back
    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] now;
        logic [31:0] deadline;
        logic [15:0] payload;
        logic [15:0] key;
        logic [15:0] handle;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] out_handle;
        logic [15:0] out_payload;
        logic [5:0]  removed_count;
    } res_t;

    typedef struct packed {
        logic [31:0] deadline;
        logic [15:0] payload;
        logic [15:0] key;
        logic [15:0] handle;
    } entry_t;

endpackage

/* rtl/core/tdq_front.sv */
module tdq_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [1:0]     command,
    input  logic [31:0]    now,
    input  logic [23:0]    delay,
    input  logic [15:0]    payload,
    input  logic [15:0]    receiver_key,
    input  logic [15:0]    handle,
    output logic           q_valid,
    input  logic           q_ready,
    output tdq_pkg::cmd_t  q_data
);

    tdq_pkg::cmd_t mem_reg [tdq_pkg::QDepth];
    logic [1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [32:0] sum;
    tdq_pkg::cmd_t item;
    logic push, pop;

    always_comb begin
        sum = {1'b0, now} + {9'd0, delay};
        item.cmd = command;
        item.now = now;
        item.deadline = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        item.payload = payload;
        item.key = receiver_key;
        item.handle = handle;
    end

    assign in_ready = (wr_reg - rd_reg) != 2'd2;
    assign q_valid = wr_reg != rd_reg;
    assign q_data = mem_reg[rd_reg[0]];
    assign push = in_valid && in_ready;
    assign pop = q_valid && q_ready;
    assign wr_next = wr_reg + {1'b0, push};
    assign rd_next = rd_reg + {1'b0, pop};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= '0;
            rd_reg <= '0;
        end else begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
        end
        if (push) mem_reg[wr_reg[0]] <= item;
    end

endmodule

/* rtl/core/tdq_back.sv */
`include "timer_deadline_queue_macros.svh"
module tdq_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    output logic           q_ready,
    input  tdq_pkg::cmd_t  q_data,
    output logic           r_valid,
    input  logic           r_ready,
    output tdq_pkg::res_t  r_data
);

    localparam int D = tdq_pkg::Depth;
    localparam int CW = tdq_pkg::CountW;

    tdq_pkg::entry_t ent_reg [D];
    tdq_pkg::entry_t ent_next [D];
    tdq_pkg::entry_t ent_shift [D];
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [15:0] hnd_reg, hnd_next;
    logic [5:0] acc_reg, acc_next;
    logic r_valid_reg;
    tdq_pkg::res_t res_reg, res_next;
    logic take;
    logic step;
    logic hit;

    logic [D-1:0] lt, match, kill, prior, gone;
    logic full;

    // cancel by key drops one match a cycle and holds the word until none is left
    assign step = q_valid && (q_data.cmd == tdq_pkg::CMD_CANCEL_KEY) && hit;
    assign q_ready = (!r_valid_reg || r_ready) && !step;
    assign take = q_valid && q_ready;
    assign r_valid = r_valid_reg;
    assign r_data = res_reg;
    assign full = cnt_reg == CW'(D);
    assign hit = |match;

    // per-cell compare flags; the chain shifts one slot per cell
    always_comb begin
        for (int i = 0; i < D; i++) begin
            lt[i] = (CW'(i) < cnt_reg) && (ent_reg[i].deadline < q_data.deadline);
            match[i] = (CW'(i) < cnt_reg) &&
                ((q_data.cmd == tdq_pkg::CMD_CANCEL_HANDLE) ?
                 (ent_reg[i].handle == q_data.handle) :
                 (ent_reg[i].key == q_data.key));
        end
        // first match only
        prior[0] = 1'b0;
        for (int i = 1; i < D; i++) prior[i] = prior[i-1] | match[i-1];
        kill = '0;
        unique case (q_data.cmd)
            tdq_pkg::CMD_TICK:
                kill[0] = (cnt_reg != '0) && (q_data.now >= ent_reg[0].deadline);
            tdq_pkg::CMD_CANCEL_HANDLE: kill = match & ~prior;
            tdq_pkg::CMD_CANCEL_KEY: kill = match & ~prior;
            default: kill = '0;
        endcase
    end

    // entries at and after the removed slot move up by one
    always_comb begin
        gone[0] = kill[0];
        for (int i = 1; i < D; i++) gone[i] = gone[i-1] | kill[i];
        for (int i = 0; i < D - 1; i++)
            ent_shift[i] = gone[i] ? ent_reg[i+1] : ent_reg[i];
        ent_shift[D-1] = ent_reg[D-1];
    end

    always_comb begin
        tdq_pkg::entry_t neu;
        neu.deadline = q_data.deadline;
        neu.payload = q_data.payload;
        neu.key = q_data.key;
        neu.handle = hnd_reg;
        for (int i = 0; i < D; i++) ent_next[i] = ent_reg[i];
        cnt_next = cnt_reg;
        hnd_next = hnd_reg;
        acc_next = acc_reg;
        res_next = res_reg;
        if (step) begin
            for (int i = 0; i < D; i++) ent_next[i] = ent_shift[i];
            cnt_next = cnt_reg - CW'(1);
            acc_next = acc_reg + 6'd1;
        end else if (take) begin
            res_next = '0;
            unique case (q_data.cmd)
                tdq_pkg::CMD_ADD: begin
                    if (full) begin
                        res_next.status = tdq_pkg::ST_FULL;
                    end else begin
                        ent_next[0] = lt[0] ? ent_reg[0] : neu;
                        for (int i = 1; i < D; i++) begin
                            if (lt[i]) ent_next[i] = ent_reg[i];
                            else if (lt[i-1]) ent_next[i] = neu;
                            else ent_next[i] = ent_reg[i-1];
                        end
                        cnt_next = cnt_reg + 1'b1;
                        hnd_next = hnd_reg + 16'd1;
                        res_next.status = tdq_pkg::ST_ADDED;
                        res_next.out_handle = hnd_reg;
                    end
                end
                tdq_pkg::CMD_TICK: begin
                    for (int i = 0; i < D; i++) ent_next[i] = ent_shift[i];
                    if (kill[0]) begin
                        cnt_next = cnt_reg - CW'(1);
                        res_next.status = tdq_pkg::ST_FIRED;
                        res_next.out_handle = ent_reg[0].handle;
                        res_next.out_payload = ent_reg[0].payload;
                    end else begin
                        res_next.status = tdq_pkg::ST_IDLE;
                    end
                end
                tdq_pkg::CMD_CANCEL_HANDLE: begin
                    for (int i = 0; i < D; i++) ent_next[i] = ent_shift[i];
                    if (hit) begin
                        cnt_next = cnt_reg - CW'(1);
                        res_next.status = tdq_pkg::ST_CANCELLED;
                    end else begin
                        res_next.status = tdq_pkg::ST_NOT_FOUND;
                    end
                    res_next.removed_count = {5'd0, hit};
                end
                tdq_pkg::CMD_CANCEL_KEY: begin
                    res_next.status = (acc_reg != '0) ? tdq_pkg::ST_CANCELLED :
                                                        tdq_pkg::ST_NOT_FOUND;
                    res_next.removed_count = acc_reg;
                    acc_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            hnd_reg <= '0;
            acc_reg <= '0;
            r_valid_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            hnd_reg <= hnd_next;
            acc_reg <= acc_next;
            if (take) r_valid_reg <= 1'b1;
            else if (r_ready) r_valid_reg <= 1'b0;
        end
        for (int i = 0; i < D; i++) ent_reg[i] <= ent_next[i];
        res_reg <= res_next;
    end

    `TDQ_ASSERT(a_cnt_range, aclk, aresetn, cnt_reg <= CW'(D))
    `TDQ_ASSERT_NEXT(a_full_hold, aclk, aresetn,
        take && full && q_data.cmd == tdq_pkg::CMD_ADD, cnt_reg == CW'(D))
    `TDQ_ASSERT_NEXT(a_res_after_take, aclk, aresetn, take, r_valid_reg)
    `TDQ_ASSERT_NEXT(a_hnd_step, aclk, aresetn,
        take && !full && q_data.cmd == tdq_pkg::CMD_ADD, hnd_reg == $past(hnd_reg) + 16'd1)

endmodule

/* rtl/core/timer_deadline_queue.sv */
// a command's result word is registered: it is valid in the cycle after the entry chain accepts
// the command word, so the result handshake follows the command queue and then the result register
// throughput: one command a cycle while the output takes words; a cancel by receiver key
// holds the entry chain while it removes the matching timers one at a time
// a two-word command queue parts the input side from the entry chain
// reset: synchronous, active low; empties the queue and the chain, handle counter to zero
module timer_deadline_queue (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // command[1:0], now[33:2], delay[57:34], payload[73:58], receiver_key[89:74],
    // handle[105:90]
    input  logic [111:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0], out_handle[18:3], out_payload[34:19], removed_count[40:35]
    output logic [47:0]  m_tdata
);

    tdq_pkg::cmd_t q_data;
    tdq_pkg::res_t r_data;
    logic q_valid, q_ready;

    tdq_front u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready),
        .command(s_tdata[1:0]), .now(s_tdata[33:2]), .delay(s_tdata[57:34]),
        .payload(s_tdata[73:58]), .receiver_key(s_tdata[89:74]),
        .handle(s_tdata[105:90]),
        .q_valid, .q_ready, .q_data
    );

    tdq_back u_back (
        .aclk, .aresetn,
        .q_valid, .q_ready, .q_data,
        .r_valid(m_tvalid), .r_ready(m_tready), .r_data
    );

    assign m_tdata = {7'd0, r_data.removed_count, r_data.out_payload,
                      r_data.out_handle, r_data.status};

endmodule
